// ----- hw/rtl/lmst_pkg.sv -----
`timescale 1ns / 1ps

package lmst_pkg;

    localparam int OP_W       = 2;
    localparam int TREE_SEL_W = 5;
    localparam int POS_IN_W   = 11;
    localparam int CFG_W      = 11;
    localparam int VAL_W      = 32;
    localparam int MAX_W      = 31;
    localparam int APB_DW     = 32;
    localparam int APB_AW     = 2;

    localparam logic [OP_W-1:0] OP_SET = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD = 2'd1;
    localparam logic [OP_W-1:0] OP_QRY = 2'd2;

    localparam logic [APB_AW-1:0] REG_POSITIONS = 2'd0;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ENTER,
        ST_COV,
        ST_ADD_PD,
        ST_PD_1,
        ST_PD_2,
        ST_PD_3,
        ST_PD_4,
        ST_DESCEND,
        ST_RETURN,
        ST_RESUME,
        ST_PU_A,
        ST_PU_WR,
        ST_DONE
    } t_state;

endpackage

// ----- hw/rtl/lazy_max_segment_tree.sv -----
`timescale 1ns / 1ps

// Lazy segment trees (point set, range add, range max) over positions 1..n,
// one tree per tree_select. After reset the block runs a clearing pass over
// all NUM_TREES * 2**($clog2(POSITIONS)+1) entries of both node stores (53248
// at the default sizes) with busy high. An item is taken when start is high
// and busy low; busy then stays high until the item is finished. Ignored
// items and queries that need no tree walk go straight to the done state.
// Otherwise the sequencer walks the tree node by node, pushing a pending add
// down to both children before it descends and, for sets and adds, pulling
// the maximum of the two children up on the way back. Each node store has a
// single read port, and one shared 32-bit adder serves both stores. A query
// result is shown on o_range_max for one cycle with o_result_valid, in the
// first cycle with busy low after the item; the receiver cannot stall it.
module lazy_max_segment_tree #(
    parameter int POSITIONS = 1024,
    parameter int NUM_TREES = 26
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [lmst_pkg::OP_W-1:0]       i_operation,
    input  logic [lmst_pkg::TREE_SEL_W-1:0] i_tree_select,
    input  logic [lmst_pkg::POS_IN_W-1:0]   i_range_low,
    input  logic [lmst_pkg::POS_IN_W-1:0]   i_range_high,
    input  logic signed [lmst_pkg::VAL_W-1:0] i_value,
    output logic                          o_result_valid,
    output logic [lmst_pkg::MAX_W-1:0]      o_range_max,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lmst_pkg::APB_AW-1:0]     paddr,
    input  logic [lmst_pkg::APB_DW-1:0]     pwdata,
    output logic [lmst_pkg::APB_DW-1:0]     prdata,
    output logic                          pready
);

    import lmst_pkg::*;

    localparam int PW_MIN = $clog2(POSITIONS + 1);
    localparam int PW     = (PW_MIN > POS_IN_W) ? PW_MIN : POS_IN_W;
    localparam int NW     = $clog2(POSITIONS) + 1;
    localparam int TW     = (NUM_TREES > 1) ? $clog2(NUM_TREES) : 1;
    localparam int AW     = TW + NW;
    localparam int DEPTH  = NUM_TREES * (2 ** NW);
    localparam int DEPW   = $clog2(NW);
    localparam int CFG_RST = (POSITIONS > 2047) ? 2047 : POSITIONS;

    localparam logic [AW-1:0]  CLR_LAST = AW'(DEPTH - 1);
    localparam logic [PW-1:0]  POS_MAX  = PW'(POSITIONS);
    localparam logic [PW-1:0]  POS_ONE  = PW'(1);
    localparam logic [NW-1:0]  NODE_ROOT = NW'(1);

    t_state r_state, n_state;

    logic [OP_W-1:0]  r_op;
    logic [TW-1:0]    r_tree;
    logic [PW-1:0]    r_lo, r_hi;
    logic [VAL_W-1:0] r_val;
    logic [NW-1:0]    r_node;
    logic [PW-1:0]    r_l, r_r;
    logic [DEPW-1:0]  r_depth;
    logic             r_went;
    logic [VAL_W-1:0] r_push;
    logic [VAL_W-1:0] r_a;
    logic [MAX_W-1:0] r_best;
    logic [AW-1:0]    r_clr;
    logic [CFG_W-1:0] r_cfg;
    logic [MAX_W-1:0] r_out;
    logic             r_out_vld;

    logic [PW-1:0]    r_stk_l    [NW];
    logic [PW-1:0]    r_stk_r    [NW];
    logic             r_stk_went [NW];

    // node store ports
    logic             mx_we, mx_re, pd_we, pd_re;
    logic [AW-1:0]    mx_waddr, mx_raddr, pd_waddr, pd_raddr;
    logic [VAL_W-1:0] mx_wdata, pd_wdata, mx_rd, pd_rd;

    // shared adder
    logic [VAL_W-1:0] add_a, add_b, add_sum;

    logic [PW-1:0]    n_clamp, lo_in, hi_in, lo_c, hi_c;
    logic             tree_ok, go_trav;
    logic [PW:0]      sum_lr;
    logic [PW-1:0]    mid;
    logic             covered, leaf, go_right, resume_right;
    logic [NW-1:0]    child_l, child_r;
    logic [DEPW-1:0]  depth_up;
    logic             cfg_wr;

    // ---------------------------------------------------------------
    // common decode
    // ---------------------------------------------------------------
    always_comb begin
        if (r_cfg == '0) begin
            n_clamp = POS_ONE;
        end else if (PW'(r_cfg) > POS_MAX) begin
            n_clamp = POS_MAX;
        end else begin
            n_clamp = PW'(r_cfg);
        end
        lo_in   = PW'(i_range_low);
        hi_in   = PW'(i_range_high);
        lo_c    = (lo_in == '0) ? POS_ONE : lo_in;
        hi_c    = (hi_in > n_clamp) ? n_clamp : hi_in;
        tree_ok = 32'(i_tree_select) < NUM_TREES;
        go_trav = 1'b0;
        if (tree_ok) begin
            if (i_operation == OP_SET) begin
                go_trav = (lo_in != '0) && (lo_in <= n_clamp);
            end else if (i_operation == OP_ADD || i_operation == OP_QRY) begin
                go_trav = lo_c <= hi_c;
            end
        end
    end

    assign sum_lr   = {1'b0, r_l} + {1'b0, r_r};
    assign mid      = sum_lr[PW:1];
    assign leaf     = r_l == r_r;
    assign covered  = (r_op == OP_SET) ? leaf : ((r_lo <= r_l) && (r_hi >= r_r));
    assign child_l  = {r_node[NW-2:0], 1'b0};
    assign child_r  = {r_node[NW-2:0], 1'b1};
    assign go_right = (r_op == OP_SET) ? (r_lo > mid) : (r_lo > mid);
    assign resume_right = !r_went && (r_op != OP_SET) && (r_hi > mid);
    assign depth_up = r_depth + 1'b1;
    assign add_sum  = add_a + add_b;
    assign cfg_wr   = psel && penable && pwrite;

    // ---------------------------------------------------------------
    // next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:   if (r_clr == CLR_LAST) n_state = ST_IDLE;
            ST_IDLE: begin
                if (start) begin
                    n_state = go_trav ? ST_ENTER : ST_DONE;
                end
            end
            ST_ENTER: begin
                if (covered) begin
                    n_state = (r_op == OP_SET) ? ST_RETURN : ST_COV;
                end else if (leaf) begin
                    n_state = ST_RETURN;
                end else begin
                    n_state = ST_PD_1;
                end
            end
            ST_COV:     n_state = (r_op == OP_ADD) ? ST_ADD_PD : ST_RETURN;
            ST_ADD_PD:  n_state = ST_RETURN;
            ST_PD_1:    n_state = (pd_rd == '0) ? ST_DESCEND : ST_PD_2;
            ST_PD_2:    n_state = ST_PD_3;
            ST_PD_3:    n_state = ST_PD_4;
            ST_PD_4:    n_state = ST_DESCEND;
            ST_DESCEND: n_state = ST_ENTER;
            ST_RETURN:  n_state = (r_depth == '0) ? ST_DONE : ST_RESUME;
            ST_RESUME: begin
                if (resume_right) begin
                    n_state = ST_ENTER;
                end else if (r_op == OP_QRY) begin
                    n_state = ST_RETURN;
                end else begin
                    n_state = ST_PU_A;
                end
            end
            ST_PU_A:    n_state = ST_PU_WR;
            ST_PU_WR:   n_state = ST_RETURN;
            ST_DONE:    n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // store port control and adder operands
    // ---------------------------------------------------------------
    always_comb begin
        mx_we    = 1'b0;
        mx_re    = 1'b0;
        pd_we    = 1'b0;
        pd_re    = 1'b0;
        mx_waddr = {r_tree, r_node};
        mx_raddr = {r_tree, r_node};
        pd_waddr = {r_tree, r_node};
        pd_raddr = {r_tree, r_node};
        add_a    = mx_rd;
        add_b    = r_push;
        mx_wdata = add_sum;
        pd_wdata = add_sum;
        unique case (r_state)
            ST_CLEAR: begin
                mx_we    = 1'b1;
                pd_we    = 1'b1;
                mx_waddr = r_clr;
                pd_waddr = r_clr;
                mx_wdata = '0;
                pd_wdata = '0;
            end
            ST_ENTER: begin
                if (covered && r_op == OP_SET) begin
                    mx_we    = 1'b1;
                    mx_wdata = r_val;
                end else if (covered) begin
                    mx_re = 1'b1;
                    pd_re = 1'b1;
                end else if (!leaf) begin
                    pd_re    = 1'b1;
                    mx_re    = 1'b1;
                    mx_raddr = {r_tree, child_l};
                end
            end
            ST_COV: begin
                add_b = r_val;
                mx_we = r_op == OP_ADD;
            end
            ST_ADD_PD: begin
                add_a = pd_rd;
                add_b = r_val;
                pd_we = 1'b1;
            end
            ST_PD_1: begin
                add_b = pd_rd;
                if (pd_rd != '0) begin
                    mx_we    = 1'b1;
                    mx_waddr = {r_tree, child_l};
                    mx_re    = 1'b1;
                    mx_raddr = {r_tree, child_r};
                    pd_re    = 1'b1;
                    pd_raddr = {r_tree, child_l};
                end
            end
            ST_PD_2: begin
                add_a    = pd_rd;
                pd_we    = 1'b1;
                pd_waddr = {r_tree, child_l};
                pd_re    = 1'b1;
                pd_raddr = {r_tree, child_r};
            end
            ST_PD_3: begin
                mx_we    = 1'b1;
                mx_waddr = {r_tree, child_r};
                pd_we    = 1'b1;
                pd_wdata = '0;
            end
            ST_PD_4: begin
                add_a    = pd_rd;
                pd_we    = 1'b1;
                pd_waddr = {r_tree, child_r};
            end
            ST_RESUME: begin
                if (!resume_right && r_op != OP_QRY) begin
                    mx_re    = 1'b1;
                    mx_raddr = {r_tree, child_l};
                end
            end
            ST_PU_A: begin
                mx_re    = 1'b1;
                mx_raddr = {r_tree, child_r};
            end
            ST_PU_WR: begin
                mx_we    = 1'b1;
                mx_wdata = ($signed(r_a) > $signed(mx_rd)) ? r_a : mx_rd;
            end
            ST_IDLE, ST_DESCEND, ST_RETURN, ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    lmst_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_max_ram (
        .i_clk   (i_clk),
        .i_we    (mx_we),
        .i_waddr (mx_waddr),
        .i_wdata (mx_wdata),
        .i_re    (mx_re),
        .i_raddr (mx_raddr),
        .o_rdata (mx_rd)
    );

    lmst_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_pend_ram (
        .i_clk   (i_clk),
        .i_we    (pd_we),
        .i_waddr (pd_waddr),
        .i_wdata (pd_wdata),
        .i_re    (pd_re),
        .i_raddr (pd_raddr),
        .o_rdata (pd_rd)
    );

    // ---------------------------------------------------------------
    // control registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr     <= '0;
            r_cfg     <= CFG_W'(CFG_RST);
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= (r_state == ST_DONE) && (r_op == OP_QRY);
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (cfg_wr) begin
                r_cfg <= pwdata[CFG_W-1:0];
            end
        end
    end

    // ---------------------------------------------------------------
    // walk datapath
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    r_op    <= i_operation;
                    r_tree  <= TW'(i_tree_select);
                    r_val   <= i_value;
                    r_lo    <= lo_c;
                    r_hi    <= hi_c;
                    r_best  <= '0;
                    r_node  <= NODE_ROOT;
                    r_l     <= POS_ONE;
                    r_r     <= n_clamp;
                    r_depth <= '0;
                    r_went  <= 1'b0;
                end
            end
            ST_COV: begin
                if (r_op == OP_QRY && !mx_rd[VAL_W-1] && mx_rd[MAX_W-1:0] > r_best) begin
                    r_best <= mx_rd[MAX_W-1:0];
                end
            end
            ST_PD_1: r_push <= pd_rd;
            ST_DESCEND: begin
                r_stk_l[r_depth]    <= r_l;
                r_stk_r[r_depth]    <= r_r;
                r_stk_went[r_depth] <= go_right;
                r_depth <= depth_up;
                r_node  <= go_right ? child_r : child_l;
                r_l     <= go_right ? (mid + 1'b1) : r_l;
                r_r     <= go_right ? r_r : mid;
            end
            ST_RETURN: begin
                if (r_depth != '0) begin
                    r_node  <= r_node >> 1;
                    r_l     <= r_stk_l[r_depth - 1'b1];
                    r_r     <= r_stk_r[r_depth - 1'b1];
                    r_went  <= r_stk_went[r_depth - 1'b1];
                    r_depth <= r_depth - 1'b1;
                end
            end
            ST_RESUME: begin
                if (resume_right) begin
                    r_stk_l[r_depth]    <= r_l;
                    r_stk_r[r_depth]    <= r_r;
                    r_stk_went[r_depth] <= 1'b1;
                    r_depth <= depth_up;
                    r_node  <= child_r;
                    r_l     <= mid + 1'b1;
                end
            end
            ST_PU_A: r_a <= mx_rd;
            ST_DONE: r_out <= r_best;
            default: begin
            end
        endcase
    end

    assign busy           = r_state != ST_IDLE;
    assign o_result_valid = r_out_vld;
    assign o_range_max    = r_out;
    assign prdata         = (paddr == REG_POSITIONS) ? APB_DW'(r_cfg) : '0;
    assign pready         = 1'b1;

endmodule

// ----- hw/rtl/lmst_ram.sv -----
`timescale 1ns / 1ps

module lmst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

class max_tree_scoreboard;
    localparam int TREES      = 26;
    localparam int LEAVES     = 1024;
    localparam int NODE_COUNT = 4 * LEAVES;

    bit [31:0] node_max [TREES][NODE_COUNT];
    bit [31:0] node_pend [TREES][NODE_COUNT];
    bit [10:0] positions;
    bit [30:0] expected_max [$];
    int        mismatches;

    function new();
        positions  = 11'(LEAVES);
        mismatches = 0;
    endfunction

    task report(string what, bit [30:0] got, bit [30:0] want);
        $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    function void lift(int t, int k);
        bit [31:0] a, b;
        a = node_max[t][2*k];
        b = node_max[t][2*k+1];
        node_max[t][k] = ($signed(a) > $signed(b)) ? a : b;
    endfunction

    function void spread(int t, int k);
        bit [31:0] p;
        p = node_pend[t][k];
        if (p == 0 || 2*k+1 >= NODE_COUNT) return;
        node_pend[t][2*k]   += p;
        node_pend[t][2*k+1] += p;
        node_max[t][2*k]    += p;
        node_max[t][2*k+1]  += p;
        node_pend[t][k] = 0;
    endfunction

    function void write_leaf(int t, int k, int l, int r, int pos, bit [31:0] v);
        int mid;
        if (k >= NODE_COUNT) return;
        if (l == r) begin
            node_max[t][k] = v;
            return;
        end
        if (2*k+1 >= NODE_COUNT) return;
        spread(t, k);
        mid = (l + r) >> 1;
        if (pos <= mid) write_leaf(t, 2*k, l, mid, pos, v);
        else write_leaf(t, 2*k+1, mid+1, r, pos, v);
        lift(t, k);
    endfunction

    function void add_span(int t, int k, int l, int r, int lo, int hi, bit [31:0] v);
        int mid;
        if (k >= NODE_COUNT) return;
        if (lo <= l && hi >= r) begin
            node_pend[t][k] += v;
            node_max[t][k]  += v;
            return;
        end
        if (2*k+1 >= NODE_COUNT || l == r) return;
        spread(t, k);
        mid = (l + r) >> 1;
        if (lo <= mid) add_span(t, 2*k, l, mid, lo, hi, v);
        if (hi > mid) add_span(t, 2*k+1, mid+1, r, lo, hi, v);
        lift(t, k);
    endfunction

    // largest value in the span, negatives read as zero
    function bit [31:0] span_max(int t, int k, int l, int r, int lo, int hi);
        bit [31:0] best, s;
        int mid;
        best = 0;
        if (k >= NODE_COUNT) return 0;
        if (lo <= l && hi >= r) return node_max[t][k][31] ? 32'd0 : node_max[t][k];
        if (2*k+1 >= NODE_COUNT || l == r) return 0;
        spread(t, k);
        mid = (l + r) >> 1;
        if (lo <= mid) begin
            s = span_max(t, 2*k, l, mid, lo, hi);
            if (s > best) best = s;
        end
        if (hi > mid) begin
            s = span_max(t, 2*k+1, mid+1, r, lo, hi);
            if (s > best) best = s;
        end
        return best;
    endfunction

    function void note_item(bit [1:0] op, bit [4:0] tree, bit [10:0] lo_in,
                            bit [10:0] hi_in, bit [31:0] v);
        int n, lo, hi;
        bit [31:0] m;
        n  = positions;
        lo = lo_in;
        hi = hi_in;
        if (n < 1) n = 1;
        if (n > LEAVES) n = LEAVES;
        if (op == 2'd3) return;
        if (tree >= TREES) begin
            if (op == lmst_pkg::OP_QRY) expected_max.push_back(0);
            return;
        end
        if (op == lmst_pkg::OP_SET) begin
            if (lo >= 1 && lo <= n) write_leaf(tree, 1, 1, n, lo, v);
            return;
        end
        if (lo < 1) lo = 1;
        if (hi > n) hi = n;
        if (op == lmst_pkg::OP_ADD) begin
            if (lo <= hi) add_span(tree, 1, 1, n, lo, hi, v);
            return;
        end
        m = (lo <= hi) ? span_max(tree, 1, 1, n, lo, hi) : 32'd0;
        expected_max.push_back(m[30:0]);
    endfunction

    task check_result(bit [30:0] got);
        bit [30:0] want;
        if (expected_max.size() == 0) begin
            report("unexpected range_max", got, 0);
            return;
        end
        want = expected_max.pop_front();
        if (got !== want) report("range_max", got, want);
    endtask
endclass

module tb_top;
    import lmst_pkg::*;

    localparam logic [OP_W-1:0]   OP_UNUSED     = 2'd3;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int PHASE_ITEMS    = 190;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [OP_W-1:0]       i_operation;
    logic [TREE_SEL_W-1:0] i_tree_select;
    logic [POS_IN_W-1:0]   i_range_low;
    logic [POS_IN_W-1:0]   i_range_high;
    logic signed [VAL_W-1:0] i_value;
    logic                  o_result_valid;
    logic [MAX_W-1:0]      o_range_max;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_AW-1:0]     paddr;
    logic [APB_DW-1:0]     pwdata;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    max_tree_scoreboard sb;
    int idle_cycles;
    int gap_pct;

    lazy_max_segment_tree dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_operation(i_operation), .i_tree_select(i_tree_select),
        .i_range_low(i_range_low), .i_range_high(i_range_high), .i_value(i_value),
        .o_result_valid(o_result_valid), .o_range_max(o_range_max),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) sb.check_result(o_range_max);
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // presents one beat and holds it until the block takes it
    task send_item(logic [1:0] op, logic [4:0] tree, logic [10:0] lo,
                   logic [10:0] hi, logic [31:0] v);
        i_operation   <= op;
        i_tree_select <= tree;
        i_range_low   <= lo;
        i_range_high  <= hi;
        i_value       <= v;
        start         <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_item(op, tree, lo, hi, v);
        if ($urandom_range(0, 99) < gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task wait_quiet();
        start <= 1'b0;
        @(posedge i_clk);
        @(posedge i_clk);
        while (busy || sb.expected_max.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task write_positions(logic [10:0] n);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= REG_POSITIONS;
        pwdata  <= 32'(n);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.positions = n;
        @(posedge i_clk);
    endtask

    function logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2, 3, 4, 5: return 32'($urandom_range(0, 200)) - 32'd100;
            default: return $urandom;
        endcase
    endfunction

    function logic [10:0] pick_pos(int n);
        if ($urandom_range(0, 99) < 85) return 11'($urandom_range(1, n));
        return 11'($urandom_range(0, 2047));
    endfunction

    task random_item(int n);
        logic [1:0]  op;
        logic [4:0]  tree;
        logic [10:0] lo, hi;
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) op = OP_SET;
        else if (r < 65) op = OP_ADD;
        else if (r < 95) op = OP_QRY;
        else op = OP_UNUSED;
        tree = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                           : 5'($urandom_range(0, 3));
        lo = pick_pos(n);
        hi = ($urandom_range(0, 9) < 7) ? 11'(lo + $urandom_range(0, n)) : pick_pos(n);
        send_item(op, tree, lo, hi, pick_value());
    endtask

    initial begin
        int settings [8];
        int n;
        settings = '{1024, 1, 0, 2047, 37, 2, 600, 1024};
        sb = new();
        idle_cycles = 0;
        gap_pct = 23;
        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_operation   <= OP_SET;
        i_tree_select <= '0;
        i_range_low   <= '0;
        i_range_high  <= '0;
        i_value       <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // clearing pass after reset
        @(posedge i_clk);
        @(posedge i_clk);
        while (busy) @(posedge i_clk);

        for (int ph = 0; ph < 8; ph++) begin
            gap_pct = (ph < 3) ? 23 : (ph < 6) ? 70 : 0;
            write_positions(11'(settings[ph]));
            n = settings[ph];
            if (n < 1) n = 1;
            if (n > 1024) n = 1024;
            if (ph == 0) begin
                send_item(OP_SET, 0, 1, 0, 32'h7fff_ffff);
                send_item(OP_QRY, 0, 1, 1024, 0);
                send_item(OP_SET, 0, 1024, 0, 32'hffff_ffff);
                send_item(OP_ADD, 0, 1, 1024, 1);     // wraps position 1
                send_item(OP_QRY, 0, 1, 1024, 0);
                send_item(OP_QRY, 0, 1, 1, 0);
                send_item(OP_UNUSED, 0, 1, 1024, 5);
                send_item(OP_QRY, 31, 1, 1024, 0);
                send_item(OP_SET, 26, 5, 5, 77);
                send_item(OP_ADD, 26, 1, 1024, 77);
                send_item(OP_QRY, 25, 1, 1024, 0);
                send_item(OP_ADD, 1, 0, 2047, 32'h8000_0000);
                send_item(OP_QRY, 1, 0, 2047, 0);
                send_item(OP_ADD, 2, 900, 10, 9);     // empty span
                send_item(OP_QRY, 2, 900, 10, 0);
                send_item(OP_SET, 2, 0, 0, 33);
                send_item(OP_SET, 2, 2047, 0, 33);
                send_item(OP_ADD, 3, 1, 1024, -5);
                send_item(OP_QRY, 3, 1, 1024, 0);
                send_item(OP_SET, 3, 512, 512, 1000);
                send_item(OP_ADD, 3, 500, 600, 32'h7fff_ffff);
                send_item(OP_QRY, 3, 400, 700, 0);
            end
            for (int i = 0; i < PHASE_ITEMS; i++) random_item(n);
            wait_quiet();
        end

        if (sb.mismatches == 0 && sb.expected_max.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
